/* hdl/aabb_xf_pkg.sv */
`timescale 1ns / 1ps

package aabb_xf_pkg;

    // Field formats
    localparam int COORD_WIDTH = 16;
    localparam int COEF_WIDTH  = 16;
    localparam int COEF_FRAC   = COEF_WIDTH - 4;
    localparam int ROW_WIDTH   = 64;
    localparam int TRANS_ROOM  = ROW_WIDTH - 3 * COEF_WIDTH;
    localparam int TRANS_WIDTH = (TRANS_ROOM < COORD_WIDTH) ? TRANS_ROOM : COORD_WIDTH;
    localparam int TRANS_LSB   = 3 * COEF_WIDTH;
    localparam int NUM_AXES    = 3;

    // Datapath widths: one product, and the sum of three products plus translation
    localparam int PROD_WIDTH  = COORD_WIDTH + COEF_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 3;
    localparam int RND_WIDTH   = SUM_WIDTH - COEF_FRAC;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [COEF_WIDTH-1:0]  coef_t;
    typedef logic signed [TRANS_WIDTH-1:0] trans_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;
    typedef logic signed [RND_WIDTH-1:0]   rnd_t;
    typedef logic [ROW_WIDTH-1:0]          row_t;

    localparam sum_t ROUND_BIAS = sum_t'(1) <<< (COEF_FRAC - 1);
    localparam rnd_t COORD_MAX  = (rnd_t'(1) <<< (COORD_WIDTH - 1)) - rnd_t'(1);
    localparam rnd_t COORD_MIN  = -(rnd_t'(1) <<< (COORD_WIDTH - 1));

    // Round to nearest (ties up), then saturate to the coordinate range
    function automatic coord_t round_sat(input sum_t acc);
        sum_t   biased;
        rnd_t   q;
        coord_t res;
        biased = acc + ROUND_BIAS;
        q      = biased[SUM_WIDTH-1:COEF_FRAC];
        if (q > COORD_MAX) begin
            res = COORD_MAX[COORD_WIDTH-1:0];
        end else if (q < COORD_MIN) begin
            res = COORD_MIN[COORD_WIDTH-1:0];
        end else begin
            res = q[COORD_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

/* hdl/aabb_affine_transform.sv */
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// s_        s_valid / s_ready    local box, valid and planar flags, three matrix rows
// m_        m_valid / m_ready    enclosing world box, valid and planar flags
//
// Three register stages: products, per-axis min/max, then sum, round and saturate.
// One item per cycle while m_ready is high; m_valid rises once the item has passed the product,
// extreme and result registers. The bounds are separable per axis, so each output axis takes the smaller and
// larger product per input axis instead of visiting all corners.
// aresetn (synchronous, active low) clears the stage valid bits only.
// A stalled m_ side holds each stage; s_ready drops only when all stages are full.

module aabb_affine_transform (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  aabb_xf_pkg::coord_t s_box_min_x,
    input  aabb_xf_pkg::coord_t s_box_min_y,
    input  aabb_xf_pkg::coord_t s_box_min_z,
    input  aabb_xf_pkg::coord_t s_box_max_x,
    input  aabb_xf_pkg::coord_t s_box_max_y,
    input  aabb_xf_pkg::coord_t s_box_max_z,
    input  logic                s_box_valid,
    input  logic                s_flat_2d,
    input  aabb_xf_pkg::row_t   s_matrix_row_x,
    input  aabb_xf_pkg::row_t   s_matrix_row_y,
    input  aabb_xf_pkg::row_t   s_matrix_row_z,
    output logic                m_valid,
    input  logic                m_ready,
    output aabb_xf_pkg::coord_t m_world_min_x,
    output aabb_xf_pkg::coord_t m_world_min_y,
    output aabb_xf_pkg::coord_t m_world_min_z,
    output aabb_xf_pkg::coord_t m_world_max_x,
    output aabb_xf_pkg::coord_t m_world_max_y,
    output aabb_xf_pkg::coord_t m_world_max_z,
    output logic                m_world_valid,
    output logic                m_world_flat_2d
);
    import aabb_xf_pkg::*;

    // Stage valid bits and enables
    logic prod_vld_reg, ext_vld_reg, out_vld_reg;
    logic prod_en, ext_en, out_en;

    // Stage 1: products of each coefficient with the low and high coordinate
    prod_t  prod_lo_reg [NUM_AXES][NUM_AXES];
    prod_t  prod_hi_reg [NUM_AXES][NUM_AXES];
    trans_t prod_trans_reg [NUM_AXES];
    logic   prod_valid_reg, prod_flat_reg;

    prod_t  prod_lo_next [NUM_AXES][NUM_AXES];
    prod_t  prod_hi_next [NUM_AXES][NUM_AXES];
    trans_t trans_next [NUM_AXES];
    row_t   mrow [NUM_AXES];
    coord_t cmin [NUM_AXES];
    coord_t cmax [NUM_AXES];

    // Stage 2: smaller and larger product per row and local axis
    prod_t  ext_lo_reg [NUM_AXES][NUM_AXES];
    prod_t  ext_hi_reg [NUM_AXES][NUM_AXES];
    trans_t ext_trans_reg [NUM_AXES];
    logic   ext_valid_reg, ext_flat_reg;

    prod_t  ext_lo_next [NUM_AXES][NUM_AXES];
    prod_t  ext_hi_next [NUM_AXES][NUM_AXES];

    // Stage 3: result register
    coord_t wmin_reg [NUM_AXES];
    coord_t wmax_reg [NUM_AXES];
    logic   wvalid_reg, wflat_reg;

    coord_t wmin_next [NUM_AXES];
    coord_t wmax_next [NUM_AXES];

    // Advance a stage when it is empty or the one after it advances
    assign out_en  = !out_vld_reg || m_ready;
    assign ext_en  = !ext_vld_reg || out_en;
    assign prod_en = !prod_vld_reg || ext_en;
    assign s_ready = prod_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            ext_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (prod_en) begin
                prod_vld_reg <= s_valid;
            end
            if (ext_en) begin
                ext_vld_reg <= prod_vld_reg;
            end
            if (out_en) begin
                out_vld_reg <= ext_vld_reg;
            end
        end
    end

    // Unpack rows; drop local z in planar mode
    always_comb begin
        mrow[0] = s_matrix_row_x;
        mrow[1] = s_matrix_row_y;
        mrow[2] = s_matrix_row_z;
        cmin[0] = s_box_min_x;
        cmin[1] = s_box_min_y;
        cmin[2] = s_flat_2d ? '0 : s_box_min_z;
        cmax[0] = s_box_max_x;
        cmax[1] = s_box_max_y;
        cmax[2] = s_flat_2d ? '0 : s_box_max_z;
        for (int r = 0; r < NUM_AXES; r++) begin
            trans_next[r] = trans_t'(mrow[r][TRANS_LSB +: TRANS_WIDTH]);
            for (int a = 0; a < NUM_AXES; a++) begin
                prod_lo_next[r][a] = prod_t'(cmin[a])
                                   * prod_t'(coef_t'(mrow[r][a*COEF_WIDTH +: COEF_WIDTH]));
                prod_hi_next[r][a] = prod_t'(cmax[a])
                                   * prod_t'(coef_t'(mrow[r][a*COEF_WIDTH +: COEF_WIDTH]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_en) begin
            prod_lo_reg    <= prod_lo_next;
            prod_hi_reg    <= prod_hi_next;
            prod_trans_reg <= trans_next;
            prod_valid_reg <= s_box_valid;
            prod_flat_reg  <= s_flat_2d;
        end
    end

    // Order each product pair
    always_comb begin
        for (int r = 0; r < NUM_AXES; r++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                if (prod_lo_reg[r][a] < prod_hi_reg[r][a]) begin
                    ext_lo_next[r][a] = prod_lo_reg[r][a];
                    ext_hi_next[r][a] = prod_hi_reg[r][a];
                end else begin
                    ext_lo_next[r][a] = prod_hi_reg[r][a];
                    ext_hi_next[r][a] = prod_lo_reg[r][a];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ext_en) begin
            ext_lo_reg    <= ext_lo_next;
            ext_hi_reg    <= ext_hi_next;
            ext_trans_reg <= prod_trans_reg;
            ext_valid_reg <= prod_valid_reg;
            ext_flat_reg  <= prod_flat_reg;
        end
    end

    // Sum, round and saturate; clear for an invalid box, zero z in planar mode
    always_comb begin
        sum_t trans_term;
        sum_t acc_lo;
        sum_t acc_hi;
        for (int r = 0; r < NUM_AXES; r++) begin
            trans_term = sum_t'(ext_trans_reg[r]) <<< COEF_FRAC;
            acc_lo = sum_t'(ext_lo_reg[r][0]) + sum_t'(ext_lo_reg[r][1])
                   + sum_t'(ext_lo_reg[r][2]) + trans_term;
            acc_hi = sum_t'(ext_hi_reg[r][0]) + sum_t'(ext_hi_reg[r][1])
                   + sum_t'(ext_hi_reg[r][2]) + trans_term;
            wmin_next[r] = round_sat(acc_lo);
            wmax_next[r] = round_sat(acc_hi);
            if (!ext_valid_reg || (ext_flat_reg && r == NUM_AXES - 1)) begin
                wmin_next[r] = '0;
                wmax_next[r] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            wmin_reg   <= wmin_next;
            wmax_reg   <= wmax_next;
            wvalid_reg <= ext_valid_reg;
            wflat_reg  <= ext_valid_reg && ext_flat_reg;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_world_min_x   = wmin_reg[0];
    assign m_world_min_y   = wmin_reg[1];
    assign m_world_min_z   = wmin_reg[2];
    assign m_world_max_x   = wmax_reg[0];
    assign m_world_max_y   = wmax_reg[1];
    assign m_world_max_z   = wmax_reg[2];
    assign m_world_valid   = wvalid_reg;
    assign m_world_flat_2d = wflat_reg;

    // An invalid box leaves an all-zero result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_world_valid |-> m_world_min_x == '0 && m_world_max_x == '0
            && m_world_min_y == '0 && m_world_max_y == '0
            && m_world_min_z == '0 && m_world_max_z == '0 && !m_world_flat_2d)
        else $error("invalid box gave a nonzero result");

    // Planar results carry zero z bounds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_world_flat_2d |-> m_world_min_z == '0 && m_world_max_z == '0)
        else $error("planar result with nonzero z bounds");

    // Minimum and maximum come from the same corner set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_world_valid |-> m_world_min_x <= m_world_max_x
            && m_world_min_y <= m_world_max_y && m_world_min_z <= m_world_max_z)
        else $error("world minimum above maximum");

    // Input stalls only when every stage is full and the output is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready && prod_vld_reg && ext_vld_reg)
        else $error("input stalled with room in the pipeline");

endmodule

/* bench/tb_aabb_affine_transform.sv */
`timescale 1ns / 1ps

module tb_aabb_affine_transform;

    import aabb_xf_pkg::*;

    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    localparam int NUM_RANDOM   = 1000;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 10;

    localparam coef_t  ONE_COEF = 16'sd4096;
    localparam coef_t  HALF_COEF = 16'sd2048;
    localparam longint SAT_HI = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) <<< (COORD_WIDTH - 1));

    typedef struct packed {
        coord_t [2:0] lo;
        coord_t [2:0] hi;
        logic         valid;
        logic         flat;
        row_t   [2:0] rows;
    } box_item_t;

    typedef struct packed {
        coord_t [2:0] lo;
        coord_t [2:0] hi;
        logic         valid;
        logic         flat;
    } world_box_t;

    logic   aclk    = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    coord_t s_box_min_x = '0;
    coord_t s_box_min_y = '0;
    coord_t s_box_min_z = '0;
    coord_t s_box_max_x = '0;
    coord_t s_box_max_y = '0;
    coord_t s_box_max_z = '0;
    logic   s_box_valid = 1'b0;
    logic   s_flat_2d   = 1'b0;
    row_t   s_matrix_row_x = '0;
    row_t   s_matrix_row_y = '0;
    row_t   s_matrix_row_z = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    coord_t m_world_min_x;
    coord_t m_world_min_y;
    coord_t m_world_min_z;
    coord_t m_world_max_x;
    coord_t m_world_max_y;
    coord_t m_world_max_z;
    logic   m_world_valid;
    logic   m_world_flat_2d;

    box_item_t  pending_boxes[$];
    world_box_t expected_bounds[$];
    box_item_t  box_on_bus;
    int         mismatches   = 0;
    int         results_seen = 0;

    aabb_affine_transform dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_box_min_x     (s_box_min_x),
        .s_box_min_y     (s_box_min_y),
        .s_box_min_z     (s_box_min_z),
        .s_box_max_x     (s_box_max_x),
        .s_box_max_y     (s_box_max_y),
        .s_box_max_z     (s_box_max_z),
        .s_box_valid     (s_box_valid),
        .s_flat_2d       (s_flat_2d),
        .s_matrix_row_x  (s_matrix_row_x),
        .s_matrix_row_y  (s_matrix_row_y),
        .s_matrix_row_z  (s_matrix_row_z),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_world_min_x   (m_world_min_x),
        .m_world_min_y   (m_world_min_y),
        .m_world_min_z   (m_world_min_z),
        .m_world_max_x   (m_world_max_x),
        .m_world_max_y   (m_world_max_y),
        .m_world_max_z   (m_world_max_z),
        .m_world_valid   (m_world_valid),
        .m_world_flat_2d (m_world_flat_2d)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Map one corner through one matrix row: exact sum, round half up, saturate
    function automatic longint map_axis(input row_t row, input longint cx,
                                        input longint cy, input longint cz);
        longint acc;
        acc = cx * longint'($signed(row[0 +: COEF_WIDTH]))
            + cy * longint'($signed(row[COEF_WIDTH +: COEF_WIDTH]))
            + cz * longint'($signed(row[2 * COEF_WIDTH +: COEF_WIDTH]))
            + longint'($signed(row[TRANS_LSB +: TRANS_WIDTH])) * (longint'(1) <<< COEF_FRAC);
        acc = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
        if (acc > SAT_HI) acc = SAT_HI;
        if (acc < SAT_LO) acc = SAT_LO;
        return acc;
    endfunction

    // Visit every corner and keep the per-axis extremes
    function automatic world_box_t predict_bounds(input box_item_t b);
        world_box_t w;
        longint     c[3];
        longint     lo_v[3];
        longint     hi_v[3];
        longint     v;
        int         ncorner;
        w = '0;
        if (!b.valid) return w;
        ncorner = b.flat ? 4 : 8;
        for (int k = 0; k < ncorner; k++) begin
            c[AX_X] = longint'($signed((k & 1) != 0 ? b.hi[AX_X] : b.lo[AX_X]));
            c[AX_Y] = longint'($signed((k & 2) != 0 ? b.hi[AX_Y] : b.lo[AX_Y]));
            c[AX_Z] = b.flat ? 0 :
                      longint'($signed((k & 4) != 0 ? b.hi[AX_Z] : b.lo[AX_Z]));
            for (int a = 0; a < NUM_AXES; a++) begin
                v = map_axis(b.rows[a], c[AX_X], c[AX_Y], c[AX_Z]);
                if (k == 0 || v < lo_v[a]) lo_v[a] = v;
                if (k == 0 || v > hi_v[a]) hi_v[a] = v;
            end
        end
        if (b.flat) begin
            lo_v[AX_Z] = 0;
            hi_v[AX_Z] = 0;
        end
        for (int a = 0; a < NUM_AXES; a++) begin
            w.lo[a] = coord_t'(lo_v[a]);
            w.hi[a] = coord_t'(hi_v[a]);
        end
        w.valid = 1'b1;
        w.flat  = b.flat;
        return w;
    endfunction

    function automatic row_t make_row(input coef_t cx, input coef_t cy, input coef_t cz,
                                      input trans_t t);
        return row_t'({t, cz, cy, cx});
    endfunction

    function automatic box_item_t make_box(input coord_t lx, input coord_t ly,
                                           input coord_t lz, input coord_t hx,
                                           input coord_t hy, input coord_t hz,
                                           input logic valid, input logic flat,
                                           input row_t rx, input row_t ry, input row_t rz);
        box_item_t b;
        b.lo    = {lz, ly, lx};
        b.hi    = {hz, hy, hx};
        b.valid = valid;
        b.flat  = flat;
        b.rows  = {rz, ry, rx};
        return b;
    endfunction

    // Mostly moderate transforms, some raw bits, some near the coefficient limits
    function automatic row_t random_row();
        int   mode;
        row_t r;
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
            r = make_row(coef_t'(int'($urandom_range(0, 16383)) - 8192),
                         coef_t'(int'($urandom_range(0, 16383)) - 8192),
                         coef_t'(int'($urandom_range(0, 16383)) - 8192),
                         trans_t'(int'($urandom_range(0, 16383)) - 8192));
        end else if (mode < 9) begin
            r = {$urandom, $urandom};
        end else begin
            r = make_row($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000,
                         $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000,
                         $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000,
                         trans_t'($urandom));
        end
        return r;
    endfunction

    // Ordered boxes of modest size mostly, with full-range and inverted ones mixed in
    function automatic box_item_t random_box();
        box_item_t b;
        int        mode;
        coord_t    p;
        coord_t    q;
        coord_t    t;
        mode = $urandom_range(0, 9);
        for (int a = 0; a < NUM_AXES; a++) begin
            if (mode < 6) begin
                p = coord_t'(int'($urandom_range(0, 8191)) - 4096);
                q = coord_t'(int'($urandom_range(0, 8191)) - 4096);
            end else begin
                p = coord_t'($urandom);
                q = coord_t'($urandom);
            end
            if (mode != 9 && p > q) begin
                t = p;
                p = q;
                q = t;
            end
            b.lo[a] = p;
            b.hi[a] = q;
        end
        b.valid = ($urandom_range(0, 9) != 0);
        b.flat  = ($urandom_range(0, 3) == 0);
        for (int a = 0; a < NUM_AXES; a++) begin
            b.rows[a] = random_row();
        end
        return b;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
            end
        end
    endtask

    // Drive the input channel from the pending queue
    int tx_gap  = 0;
    int tx_calm = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_bounds.push_back(predict_bounds(box_on_bus));
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (pending_boxes.size() != 0) begin
                    box_on_bus = pending_boxes.pop_front();
                    s_box_min_x    <= box_on_bus.lo[AX_X];
                    s_box_min_y    <= box_on_bus.lo[AX_Y];
                    s_box_min_z    <= box_on_bus.lo[AX_Z];
                    s_box_max_x    <= box_on_bus.hi[AX_X];
                    s_box_max_y    <= box_on_bus.hi[AX_Y];
                    s_box_max_z    <= box_on_bus.hi[AX_Z];
                    s_box_valid    <= box_on_bus.valid;
                    s_flat_2d      <= box_on_bus.flat;
                    s_matrix_row_x <= box_on_bus.rows[AX_X];
                    s_matrix_row_y <= box_on_bus.rows[AX_Y];
                    s_matrix_row_z <= box_on_bus.rows[AX_Z];
                    s_valid        <= 1'b1;
                    if (tx_calm > 0) begin
                        tx_calm--;
                        tx_gap = 0;
                    end else begin
                        tx_gap = pick_gap();
                        if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(20, 80);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Throttle the result channel; hold off once for a long stretch
    int   rx_stall  = 0;
    int   rx_calm   = 0;
    logic hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rx_stall  = HOLD_CYCLES;
            m_ready  <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else if (rx_calm > 0) begin
            rx_calm--;
            m_ready <= 1'b1;
        end else begin
            rx_stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(20, 80);
            m_ready <= (rx_stall == 0);
        end
    end

    // Compare each accepted result with the oldest expectation
    world_box_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_bounds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result item with no expectation waiting");
            end else begin
                want = expected_bounds.pop_front();
                check_field("world_min_x", $signed(want.lo[AX_X]), m_world_min_x);
                check_field("world_min_y", $signed(want.lo[AX_Y]), m_world_min_y);
                check_field("world_min_z", $signed(want.lo[AX_Z]), m_world_min_z);
                check_field("world_max_x", $signed(want.hi[AX_X]), m_world_max_x);
                check_field("world_max_y", $signed(want.hi[AX_Y]), m_world_max_y);
                check_field("world_max_z", $signed(want.hi[AX_Z]), m_world_max_z);
                check_field("world_valid", want.valid, m_world_valid);
                check_field("world_flat_2d", want.flat, m_world_flat_2d);
            end
        end
    end

    // Build the stimulus, release reset, wait for the drain, report
    initial begin
        row_t id_x;
        row_t id_y;
        row_t id_z;
        row_t sat_hi;
        row_t sat_lo;
        id_x   = make_row(ONE_COEF, 16'sd0, 16'sd0, 16'sd0);
        id_y   = make_row(16'sd0, ONE_COEF, 16'sd0, 16'sd0);
        id_z   = make_row(16'sd0, 16'sd0, ONE_COEF, 16'sd0);
        sat_hi = make_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        sat_lo = make_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);

        // identity, 3D and planar
        pending_boxes.push_back(make_box(-16'sh0100, -16'sh0200, -16'sh0300,
                                         16'sh0100, 16'sh0200, 16'sh0300,
                                         1'b1, 1'b0, id_x, id_y, id_z));
        pending_boxes.push_back(make_box(-16'sh0100, -16'sh0200, -16'sh0300,
                                         16'sh0100, 16'sh0200, 16'sh0300,
                                         1'b1, 1'b1, id_x, id_y, id_z));
        // invalid box, with and without the planar flag
        pending_boxes.push_back(make_box(coord_t'($urandom), coord_t'($urandom),
                                         coord_t'($urandom), coord_t'($urandom),
                                         coord_t'($urandom), coord_t'($urandom),
                                         1'b0, 1'b1, {$urandom, $urandom},
                                         {$urandom, $urandom}, {$urandom, $urandom}));
        pending_boxes.push_back(make_box(16'sh1234, 16'sh0567, -16'sh0089,
                                         16'sh2000, 16'sh0600, 16'sh0100,
                                         1'b0, 1'b0, id_x, id_y, id_z));
        pending_boxes.push_back(make_box('1, '1, '1, '1, '1, '1, 1'b0, 1'b1, '1, '1, '1));
        // coordinate and coefficient extremes, driving saturation both ways
        pending_boxes.push_back(make_box(16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                         16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                         1'b1, 1'b0, sat_hi, sat_hi, sat_hi));
        pending_boxes.push_back(make_box(16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                         16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                         1'b1, 1'b0, sat_lo, sat_lo, sat_lo));
        pending_boxes.push_back(make_box(16'sh8000, 16'sh8000, 16'sh8000,
                                         16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                         1'b1, 1'b0, sat_hi, sat_lo, id_z));
        pending_boxes.push_back(make_box(16'sh8000, 16'sh8000, 16'sh8000,
                                         16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                         1'b1, 1'b1, id_x, id_y, id_z));
        // translation only, at both limits
        pending_boxes.push_back(make_box(-16'sh0400, -16'sh0400, -16'sh0400,
                                         16'sh0400, 16'sh0400, 16'sh0400, 1'b1, 1'b0,
                                         make_row(16'sd0, 16'sd0, 16'sd0, 16'sh7FFF),
                                         make_row(16'sd0, 16'sd0, 16'sd0, 16'sh8000),
                                         make_row(16'sd0, 16'sd0, 16'sd0, 16'sh1234)));
        // inverted box under a quarter turn about z
        pending_boxes.push_back(make_box(16'sh0200, 16'sh0200, 16'sh0200,
                                         -16'sh0200, -16'sh0100, -16'sh0300, 1'b1, 1'b0,
                                         make_row(16'sd0, -ONE_COEF, 16'sd0, 16'sh0080),
                                         make_row(ONE_COEF, 16'sd0, 16'sd0, -16'sh0080),
                                         id_z));
        // rounding ties on both signs
        pending_boxes.push_back(make_box(-16'sd1, -16'sd1, -16'sd1,
                                         16'sd1, 16'sd1, 16'sd1, 1'b1, 1'b0,
                                         make_row(HALF_COEF, 16'sd0, 16'sd0, 16'sd0),
                                         make_row(-HALF_COEF, 16'sd0, 16'sd0, 16'sd0),
                                         make_row(HALF_COEF, HALF_COEF, HALF_COEF, 16'sd0)));
        // planar mode ignores large z terms and z coordinates
        pending_boxes.push_back(make_box(-16'sh0100, 16'sh0000, 16'sh8000,
                                         16'sh0300, 16'sh0100, 16'sh7FFF, 1'b1, 1'b1,
                                         make_row(ONE_COEF, 16'sd0, 16'sh7FFF, 16'sd0),
                                         make_row(16'sd0, ONE_COEF, 16'sh8000, 16'sd0),
                                         make_row(ONE_COEF, ONE_COEF, 16'sh7FFF, 16'sh0500)));
        // all-ones rows, all-zero item, half scale with offset
        pending_boxes.push_back(make_box(-16'sh0010, -16'sh0020, -16'sh0030,
                                         16'sh0040, 16'sh0050, 16'sh0060,
                                         1'b1, 1'b0, '1, '1, '1));
        pending_boxes.push_back(make_box('0, '0, '0, '0, '0, '0, 1'b1, 1'b0, '0, '0, '0));
        pending_boxes.push_back(make_box(-16'sh1000, -16'sh0800, -16'sh0001,
                                         16'sh0FFF, 16'sh0801, 16'sh0002, 1'b1, 1'b0,
                                         make_row(HALF_COEF, -HALF_COEF, 16'sd0, -16'sh0333),
                                         make_row(16'sd0, HALF_COEF, HALF_COEF, 16'sh0333),
                                         make_row(-HALF_COEF, 16'sd0, HALF_COEF, -16'sh7000)));

        for (int i = 0; i < NUM_RANDOM; i++) begin
            pending_boxes.push_back(random_box());
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_boxes.size() != 0 || s_valid || expected_bounds.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_bounds.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Give up long after the slowest correct run would have finished
    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
